@@ hw/rtl/pixel_to_rgba8_converter_macros.svh @@
// ----------------------------------------------------------------------------
// pixel_to_rgba8_converter assertion macros
// shared concurrent assertion forms for the converter checker
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_RGBA8_CONVERTER_MACROS_SVH
`define PIXEL_TO_RGBA8_CONVERTER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PR8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pr8 assertion failed");

// next-cycle implication, disabled in reset
`define PR8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pr8 assertion failed");

`endif

@@ hw/rtl/pr8_pkg.sv @@
// ----------------------------------------------------------------------------
// pr8_pkg
// source format codes shared by the converter modules
// ----------------------------------------------------------------------------
`default_nettype none

package pr8_pkg;

  localparam int unsigned FmtWidth = 3;

  typedef enum logic [FmtWidth-1:0] {
    FMT_GRAY        = 3'd0,
    FMT_COPY        = 3'd1,
    FMT_UNORM16     = 3'd2,
    FMT_SNORM16     = 3'd3,
    FMT_HALF        = 3'd4,
    FMT_FLOAT32     = 3'd5,
    FMT_UNSUPPORTED = 3'd6
  } fmt_t;

endpackage

`default_nettype wire

@@ hw/rtl/pr8_chan_conv.sv @@
// ----------------------------------------------------------------------------
// pr8_chan_conv
// converts one channel word to an 8-bit unorm byte for the selected format
// ----------------------------------------------------------------------------
`default_nettype none

module pr8_chan_conv (
  input  pr8_pkg::fmt_t fmt,
  input  logic [31:0]   word,
  output logic [7:0]    res
);

  logic [16:0] un_w;
  logic [8:0]  un_q;

  logic [15:0] sn_t;
  logic [23:0] sn_y;
  logic [22:0] sn_z;
  logic [15:0] sn_rem;
  logic [8:0]  sn_q;

  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [7:0]  f_exp;
  logic [22:0] f_man;

  logic        fp_zero;
  logic        fp_sat;
  logic [23:0] fp_m;
  logic [5:0]  fp_k;
  logic [33:0] fp_prod;
  logic [33:0] fp_sum;
  logic [33:0] fp_sh;
  logic [7:0]  fp_q;

  // unorm16: floor((u + 128) / 257)
  always_comb begin
    un_w = {1'b0, word[15:0]} + 17'd128;
    un_q = un_w[16:8] - 9'({1'b0, un_w[7:0]} < un_w[16:8]);
  end

  // snorm16: floor((255t + 32767) / 65534), clamped at -32767
  always_comb begin
    if (word[15]) begin
      sn_t = (word[15:0] == 16'h8000) ? 16'd0 : (word[15:0] - 16'd32769);
    end else begin
      sn_t = word[15:0] + 16'd32767;
    end
    sn_y   = ({sn_t, 8'd0} - {8'd0, sn_t}) + 24'd32767;
    sn_z   = sn_y[23:1];
    sn_rem = {1'b0, sn_z[14:0]} + {8'd0, sn_z[22:15]};
    sn_q   = {1'b0, sn_z[22:15]} + 9'(sn_rem >= 16'd32767);
  end

  // half / float32 unpack to m / 2^k
  always_comb begin
    h_exp   = word[14:10];
    h_man   = word[9:0];
    f_exp   = word[30:23];
    f_man   = word[22:0];
    fp_zero = 1'b0;
    fp_sat  = 1'b0;
    fp_m    = 24'd0;
    fp_k    = 6'd0;
    if (fmt == pr8_pkg::FMT_HALF) begin
      if (((h_exp == 5'h1F) && (h_man != 10'd0)) || word[15]) begin
        fp_zero = 1'b1;
      end else if (h_exp >= 5'd15) begin
        fp_sat = 1'b1;
      end else if (h_exp == 5'd0) begin
        fp_m = {14'd0, h_man};
        fp_k = 6'd24;
      end else begin
        fp_m = {13'd0, 1'b1, h_man};
        fp_k = 6'd25 - {1'b0, h_exp};
      end
    end else begin
      if (((f_exp == 8'hFF) && (f_man != 23'd0)) || word[31]) begin
        fp_zero = 1'b1;
      end else if (f_exp >= 8'd127) begin
        fp_sat = 1'b1;
      end else if (f_exp < 8'd118) begin
        fp_zero = 1'b1;
      end else begin
        fp_m = {1'b1, f_man};
        fp_k = 6'(8'd150 - f_exp);
      end
    end
  end

  // floor((510m + 2^k) / 2^(k+1))
  always_comb begin
    fp_prod = ({10'd0, fp_m} << 9) - ({10'd0, fp_m} << 1);
    fp_sum  = fp_prod + (34'd1 << fp_k);
    fp_sh   = fp_sum >> (fp_k + 6'd1);
    if (fp_zero) begin
      fp_q = 8'd0;
    end else if (fp_sat || (|fp_sh[33:8])) begin
      fp_q = 8'hFF;
    end else begin
      fp_q = fp_sh[7:0];
    end
  end

  always_comb begin
    unique case (fmt)
      pr8_pkg::FMT_GRAY,
      pr8_pkg::FMT_COPY:    res = word[7:0];
      pr8_pkg::FMT_UNORM16: res = un_q[7:0];
      pr8_pkg::FMT_SNORM16: res = sn_q[7:0];
      pr8_pkg::FMT_HALF,
      pr8_pkg::FMT_FLOAT32: res = fp_q;
      default:              res = 8'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/pixel_to_rgba8_converter.sv @@
// ----------------------------------------------------------------------------
// pixel_to_rgba8_converter
// converts one four-channel source pixel per beat into an rgba8 pixel
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries four 32-bit channel words per
//   beat; the result channel out_valid / out_stall carries four bytes. A beat
//   moves on a rising edge with valid high and stall low.
//   cfg_wr_en / cfg_wr_data set the source format; write it only while no
//   pixel is in flight.
//   A pixel accepted into the input register is converted and captured in
//   the result register, which drives out_*.
//   Throughput: one pixel per cycle while out_stall is low, set by the single
//   conversion stage between the two registers.
//   Reset (rst_n low, synchronous) empties both registers and sets the
//   format to gray. While out_stall is high with a result held, the result
//   holds, one more pixel is taken into the input register, and in_stall
//   then rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_rgba8_converter (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_chan_red,
  input  logic [31:0] in_chan_green,
  input  logic [31:0] in_chan_blue,
  input  logic [31:0] in_chan_alpha,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  pr8_pkg::fmt_t fmt_r;

  logic        s1_vld_r;
  logic        s1_vld_nxt;
  logic [31:0] s1_red_r;
  logic [31:0] s1_green_r;
  logic [31:0] s1_blue_r;
  logic [31:0] s1_alpha_r;

  logic        out_vld_r;
  logic        out_vld_nxt;
  logic [7:0]  out_red_r;
  logic [7:0]  out_green_r;
  logic [7:0]  out_blue_r;
  logic [7:0]  out_alpha_r;

  logic        out_adv;
  logic        s1_load;
  logic        gray;
  logic [31:0] green_word;
  logic [31:0] blue_word;
  logic [7:0]  conv_red;
  logic [7:0]  conv_green;
  logic [7:0]  conv_blue;
  logic [7:0]  conv_alpha;

  always_comb begin
    out_adv     = !out_vld_r || !out_stall;
    s1_load     = !s1_vld_r || out_adv;
    in_stall    = !s1_load;
    s1_vld_nxt  = s1_load ? in_valid : s1_vld_r;
    out_vld_nxt = out_adv ? s1_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= pr8_pkg::FMT_GRAY;
    end else if (cfg_wr_en) begin
      fmt_r <= pr8_pkg::fmt_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_red_r   <= in_chan_red;
      s1_green_r <= in_chan_green;
      s1_blue_r  <= in_chan_blue;
      s1_alpha_r <= in_chan_alpha;
    end
  end

  // gray replicates the red byte, alpha forced opaque
  always_comb begin
    gray       = (fmt_r == pr8_pkg::FMT_GRAY);
    green_word = gray ? s1_red_r : s1_green_r;
    blue_word  = gray ? s1_red_r : s1_blue_r;
  end

  pr8_chan_conv u_conv_red (
    .fmt  (fmt_r),
    .word (s1_red_r),
    .res  (conv_red)
  );

  pr8_chan_conv u_conv_green (
    .fmt  (fmt_r),
    .word (green_word),
    .res  (conv_green)
  );

  pr8_chan_conv u_conv_blue (
    .fmt  (fmt_r),
    .word (blue_word),
    .res  (conv_blue)
  );

  pr8_chan_conv u_conv_alpha (
    .fmt  (fmt_r),
    .word (s1_alpha_r),
    .res  (conv_alpha)
  );

  always_ff @(posedge clk) begin
    if (out_adv && s1_vld_r) begin
      out_red_r   <= conv_red;
      out_green_r <= conv_green;
      out_blue_r  <= conv_blue;
      out_alpha_r <= gray ? 8'hFF : conv_alpha;
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;

endmodule

`default_nettype wire

@@ hw/rtl/pr8_checker.sv @@
// ----------------------------------------------------------------------------
// pr8_checker
// port-level assertions for the rgba8 converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_to_rgba8_converter_macros.svh"

module pr8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_alpha
);

  logic [31:0] out_bytes;

  assign out_bytes = {out_red, out_green, out_blue, out_alpha};

  `PR8_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `PR8_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_bytes))
  `PR8_ASSERT_NOW(a_no_stall_when_free, clk, rst_n, !out_stall, !in_stall)
  `PR8_ASSERT_NEXT(a_beat_arrives, clk, rst_n, (in_valid && !in_stall) ##1 !out_stall, out_valid)

endmodule

bind pixel_to_rgba8_converter pr8_checker u_pr8_checker (.*);

`default_nettype wire

@@ verif/pixel_to_rgba8_converter_test.sv @@
// ----------------------------------------------------------------------------
// pixel_to_rgba8_converter_test
// self-checking bench for the rgba8 pixel converter: a short table of
// hand-picked pixels per source format, then random phases: the first eight
// step through format codes 0 to 7, later ones pick formats at random. Each
// accepted input beat takes its expected bytes from its table row or from an
// in-bench conversion model; result beats are compared in order, byte by byte.
// Both sides idle at random; at times the receiver holds off to back input up.
// ----------------------------------------------------------------------------
module pixel_to_rgba8_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FMT_RESERVED = 3'd7;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
  } src_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba8_t;

  typedef struct packed {
    logic [2:0] fmt;
    src_pixel_t pix;
    logic       typed_in;
    rgba8_t     want;
  } pixel_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_chan_red;
  logic [31:0] in_chan_green;
  logic [31:0] in_chan_blue;
  logic [31:0] in_chan_alpha;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;

  rgba8_t     pending_rgba[$];
  pixel_row_t pixel_table[$];
  logic [2:0] active_fmt;
  int         mismatches;
  int         hold_asks;
  int         holds_served;

  pixel_to_rgba8_converter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_chan_red   (in_chan_red),
    .in_chan_green (in_chan_green),
    .in_chan_blue  (in_chan_blue),
    .in_chan_alpha (in_chan_alpha),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha)
  );

  // floor((510 m + 2^k) / 2^(k+1)), saturated
  function automatic logic [7:0] round_pow2(logic [23:0] m, int unsigned k);
    logic [63:0] acc;
    if (k >= 33) return 8'd0;
    acc = (64'd510 * m + (64'd1 << k)) >> (k + 1);
    return (acc > 64'd255) ? 8'd255 : acc[7:0];
  endfunction

  function automatic logic [7:0] convert_channel(logic [2:0] fmt, logic [31:0] w);
    logic [63:0] u;
    logic [63:0] mag;
    logic [63:0] t;
    u = {48'd0, w[15:0]};
    case (fmt)
      pr8_pkg::FMT_COPY: return w[7:0];
      pr8_pkg::FMT_UNORM16: begin
        t = (2 * u + 257) / 514;
        return t[7:0];
      end
      pr8_pkg::FMT_SNORM16: begin
        if (w[15]) begin
          mag = 64'h10000 - u;
          if (mag > 32767) mag = 32767;
          t = 32767 - mag;
        end else begin
          t = u + 32767;
        end
        t = (255 * t + 32767) / 65534;
        return t[7:0];
      end
      pr8_pkg::FMT_HALF: begin
        if (w[14:10] == 5'h1F && w[9:0] != 0) return 8'd0;
        if (w[15]) return 8'd0;
        if (w[14:10] >= 5'd15) return 8'd255;
        if (w[14:10] == 5'd0) return round_pow2({14'd0, w[9:0]}, 24);
        return round_pow2({13'd0, 1'b1, w[9:0]}, 25 - w[14:10]);
      end
      pr8_pkg::FMT_FLOAT32: begin
        if (w[30:23] == 8'hFF && w[22:0] != 0) return 8'd0;
        if (w[31]) return 8'd0;
        if (w[30:23] >= 8'd127) return 8'd255;
        if (w[30:23] == 8'd0) return round_pow2({1'b0, w[22:0]}, 149);
        return round_pow2({1'b1, w[22:0]}, 150 - w[30:23]);
      end
      default: return 8'd0;
    endcase
  endfunction

  function automatic rgba8_t convert_pixel(logic [2:0] fmt, src_pixel_t pix);
    rgba8_t res;
    if (fmt == pr8_pkg::FMT_GRAY) begin
      res = '{pix.red[7:0], pix.red[7:0], pix.red[7:0], 8'hFF};
    end else begin
      res.red   = convert_channel(fmt, pix.red);
      res.green = convert_channel(fmt, pix.green);
      res.blue  = convert_channel(fmt, pix.blue);
      res.alpha = convert_channel(fmt, pix.alpha);
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_word(logic [2:0] fmt);
    logic [31:0] w;
    int sel;
    w = $urandom;
    sel = $urandom_range(0, 3);
    if (sel == 0) return w;
    case (fmt)
      pr8_pkg::FMT_UNORM16, pr8_pkg::FMT_SNORM16: begin
        if (sel == 1) begin
          case ($urandom_range(0, 5))
            0: w[15:0] = 16'h0000;
            1: w[15:0] = 16'h0001;
            2: w[15:0] = 16'h7FFF;
            3: w[15:0] = 16'h8000;
            4: w[15:0] = 16'h8001;
            default: w[15:0] = 16'hFFFF;
          endcase
        end
      end
      pr8_pkg::FMT_HALF: begin
        if (sel == 1) begin
          case ($urandom_range(0, 9))
            0: w[15:0] = 16'h0000;
            1: w[15:0] = 16'h8000;
            2: w[15:0] = 16'h3C00;
            3: w[15:0] = 16'h3BFF;
            4: w[15:0] = 16'h7C00;
            5: w[15:0] = 16'hFC00;
            6: w[15:0] = 16'h7E01;
            7: w[15:0] = 16'h0001;
            8: w[15:0] = 16'h03FF;
            default: w[15:0] = 16'h0400;
          endcase
        end else begin
          w[15]    = ($urandom_range(0, 7) == 0);
          w[14:10] = 5'($urandom_range(0, 16));
        end
      end
      pr8_pkg::FMT_FLOAT32: begin
        if (sel == 1) begin
          case ($urandom_range(0, 9))
            0: w = 32'h0000_0000;
            1: w = 32'h8000_0000;
            2: w = 32'h3F80_0000;
            3: w = 32'h3F7F_FFFF;
            4: w = 32'h7F80_0000;
            5: w = 32'hFF80_0000;
            6: w = 32'h7FC0_0000;
            7: w = 32'h0000_0001;
            8: w = 32'h3B80_8081;
            default: w = 32'h7F7F_FFFF;
          endcase
        end else begin
          w[31]    = ($urandom_range(0, 7) == 0);
          w[30:23] = 8'($urandom_range(110, 128));
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_row(logic [2:0] fmt, logic [31:0] r, logic [31:0] g,
                         logic [31:0] b, logic [31:0] a, logic typed_in,
                         rgba8_t want);
    pixel_table.push_back('{fmt, '{r, g, b, a}, typed_in, want});
  endtask

  task automatic send_pixel(src_pixel_t pix, logic typed_in, rgba8_t want,
                            bit gaps_on);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (gaps_on) begin
      if (roll >= 90)      gap = $urandom_range(8, 30);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_chan_red   <= pix.red;
    in_chan_green <= pix.green;
    in_chan_blue  <= pix.blue;
    in_chan_alpha <= pix.alpha;
    do @(posedge clk); while (in_stall);
    pending_rgba.push_back(typed_in ? want : convert_pixel(active_fmt, pix));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_rgba.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_format(logic [2:0] fmt);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    active_fmt = fmt;
  endtask

  task automatic check_byte(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side
  initial begin
    int roll;
    int span;
    logic hold;
    out_stall <= 1'b0;
    forever begin
      roll = $urandom_range(0, 99);
      if (hold_asks != holds_served) begin
        holds_served++;
        hold = 1'b1;
        span = HoldCycles;
      end else if (roll < 10) begin
        hold = 1'b0;
        span = $urandom_range(20, 60);
      end else if (roll < 14) begin
        hold = 1'b1;
        span = $urandom_range(8, 40);
      end else begin
        hold = ($urandom_range(0, 2) == 0);
        span = $urandom_range(1, 3);
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rgba8_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgba.size() == 0) begin
        $error("result beat with nothing expected: %02h %02h %02h %02h",
               out_red, out_green, out_blue, out_alpha);
        mismatches++;
      end else begin
        want = pending_rgba.pop_front();
        check_byte("out_red", want.red, out_red);
        check_byte("out_green", want.green, out_green);
        check_byte("out_blue", want.blue, out_blue);
        check_byte("out_alpha", want.alpha, out_alpha);
      end
    end
  end

  initial begin
    src_pixel_t pix;
    pixel_row_t row;
    logic [2:0] fmt;
    int         total;
    int         count;
    int         phase;
    bit         gaps_on;

    mismatches    = 0;
    hold_asks     = 0;
    holds_served  = 0;
    active_fmt    = pr8_pkg::FMT_GRAY;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_chan_red   <= '0;
    in_chan_green <= '0;
    in_chan_blue  <= '0;
    in_chan_alpha <= '0;

    // gray straight out of reset, then each format's edges
    add_row(pr8_pkg::FMT_GRAY, 32'hFFFF_FF80, 32'h0, 32'h0, 32'h0, 1'b1,
            '{8'h80, 8'h80, 8'h80, 8'hFF});
    add_row(pr8_pkg::FMT_GRAY, 32'h0000_00FF, '1, '1, '1, 1'b1,
            '{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    add_row(pr8_pkg::FMT_GRAY, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555, '1, 1'b1,
            '{8'h00, 8'h00, 8'h00, 8'hFF});
    add_row(pr8_pkg::FMT_COPY, 32'hFFFF_FF00, 32'h0000_00FF, 32'h1234_5678,
            32'hAAAA_AA55, 1'b1, '{8'h00, 8'hFF, 8'h78, 8'h55});
    add_row(pr8_pkg::FMT_UNORM16, 32'h0, 32'h0000_FFFF, 32'hFFFF_0000,
            32'h0000_FFFF, 1'b1, '{8'h00, 8'hFF, 8'h00, 8'hFF});
    add_row(pr8_pkg::FMT_UNORM16, 32'h8080, 32'h0001, 32'h7FFF, 32'h8000, 1'b0, '0);
    add_row(pr8_pkg::FMT_SNORM16, 32'h8000, 32'h8001, 32'h7FFF, 32'h0000, 1'b1,
            '{8'h00, 8'h00, 8'hFF, 8'h80});
    add_row(pr8_pkg::FMT_SNORM16, 32'hFFFF, 32'hABCD_0001, 32'hC000, 32'h4000,
            1'b0, '0);
    add_row(pr8_pkg::FMT_HALF, 32'h7E00, 32'hBC00, 32'h3C00, 32'h7C00, 1'b1,
            '{8'h00, 8'h00, 8'hFF, 8'hFF});
    add_row(pr8_pkg::FMT_HALF, 32'h8000, 32'hFC00, 32'h0001, 32'h7FFF, 1'b1, '0);
    add_row(pr8_pkg::FMT_HALF, 32'h3800, 32'h3BFF, 32'h03FF, 32'h1C00, 1'b0, '0);
    add_row(pr8_pkg::FMT_HALF, 32'hFFFF_3C00, 32'h1234_7BFF, 32'h0400,
            32'h5A5A_2E66, 1'b0, '0);
    add_row(pr8_pkg::FMT_FLOAT32, 32'h7FC0_0000, 32'hBF80_0000, 32'h3F80_0000,
            32'h7F80_0000, 1'b1, '{8'h00, 8'h00, 8'hFF, 8'hFF});
    add_row(pr8_pkg::FMT_FLOAT32, 32'h8000_0000, 32'hFF80_0000, 32'h0000_0001,
            32'h7F80_0001, 1'b1, '0);
    add_row(pr8_pkg::FMT_FLOAT32, 32'h3F00_0000, 32'h3F7F_FFFF, 32'h3B80_8081,
            32'h7F7F_FFFF, 1'b0, '0);
    add_row(pr8_pkg::FMT_UNSUPPORTED, '1, '1, '1, '1, 1'b1, '0);
    add_row(FMT_RESERVED, '1, '1, '1, '1, 1'b1, '0);
    add_row(pr8_pkg::FMT_GRAY, 32'h1234_56AB, 32'h0, '1, 32'h0, 1'b1,
            '{8'hAB, 8'hAB, 8'hAB, 8'hFF});
    add_row(pr8_pkg::FMT_COPY, '1, '1, '1, '1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (pixel_table[i]) begin
      row = pixel_table[i];
      if (row.fmt != active_fmt) set_format(row.fmt);
      send_pixel(row.pix, row.typed_in, row.want, 1'b1);
    end

    total = 0;
    phase = 0;
    while (total < RandomItems) begin
      fmt = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
      set_format(fmt);
      // back-pressure long enough to fill the pipe
      if (phase == 3 || phase == 10) hold_asks++;
      gaps_on = ($urandom_range(0, 3) != 0);
      count = $urandom_range(50, 100);
      repeat (count) begin
        pix.red   = pick_word(fmt);
        pix.green = pick_word(fmt);
        pix.blue  = pick_word(fmt);
        pix.alpha = pick_word(fmt);
        send_pixel(pix, 1'b0, '0, gaps_on);
        total++;
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ pixel_to_rgba8_converter.f @@
+incdir+hw/rtl
hw/rtl/pr8_pkg.sv
hw/rtl/pr8_chan_conv.sv
hw/rtl/pixel_to_rgba8_converter.sv
hw/rtl/pr8_checker.sv
verif/pixel_to_rgba8_converter_test.sv
